// ===== rtl/core/mmiw_pkg.sv =====
// shared types for the minimum modular inverse witness search
// controller/datapath command and status structs and the controller state enum
// no dependencies
package mmiw_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_SEARCH,
      ST_DIV,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_start;
      logic div_step;
      logic search_init;
      logic search_step;
      logic t_start;
      logic update;
      logic next_k;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic div_done;
      logic hit;
      logic miss;
      logic last_k;
      logic rsp_full;
   } status_type;

endpackage

// ===== rtl/core/mmiw_datapath.sv =====
// datapath: shared restoring divider, inverse search by accumulation, best tracking
// and the result register; depends on mmiw_pkg for command and status structs
module mmiw_datapath
   import mmiw_pkg::*;
#(
   parameter int MOD_BITS  = 32,
   parameter int MULT_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [31:0]          req_modulus,
   input  logic [MULT_BITS-1:0] max_mult,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [7:0]           rsp_best_multiplier,
   output logic [30:0]          rsp_best_offset,
   output logic [39:0]          rsp_product,
   output logic                 rsp_sign_plus,
   output logic [7:0]           rsp_quotient
);

   localparam int MB = MOD_BITS;
   localparam int KB = MULT_BITS;
   localparam int WB = MOD_BITS + MULT_BITS;
   localparam int CB = $clog2(WB + 1);

   logic [63:0]   req_wide;
   logic [MB-1:0] r_ff, r_in;
   logic [KB-1:0] k_ff, k_in;
   logic [WB-1:0] kr_ff, kr_in;
   logic [WB-1:0] num_ff, num_in;
   logic [KB-1:0] drem_ff, drem_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [KB-1:0] a_ff, a_in;
   logic [KB-1:0] j_ff, j_in;
   logic [KB-1:0] acc_ff, acc_in;
   logic [WB-1:0] jr_ff, jr_in;
   logic [WB-1:0] ckt_ff, ckt_in;
   logic          cplus_ff, cplus_in;
   logic [KB-1:0] cq_ff, cq_in;
   logic          found_ff, found_in;
   logic [KB-1:0] bk_ff, bk_in;
   logic [MB-2:0] bt_ff, bt_in;
   logic [WB-1:0] bkt_ff, bkt_in;
   logic          bplus_ff, bplus_in;
   logic [KB-1:0] bq_ff, bq_in;
   logic          vld_ff, vld_in;
   logic          o_found_ff, o_found_in;
   logic [KB-1:0] o_k_ff, o_k_in;
   logic [MB-2:0] o_t_ff, o_t_in;
   logic [WB-1:0] o_kt_ff, o_kt_in;
   logic          o_plus_ff, o_plus_in;
   logic [KB-1:0] o_q_ff, o_q_in;

   logic [KB:0]   trial;
   logic [KB:0]   acc_sum;
   logic [WB-1:0] num_a, num_b;
   logic          use_a;
   logic [MB-2:0] t_val;
   logic          r_two;
   logic [63:0]   t_wide, kt_wide;

   assign req_wide = 64'(req_modulus);
   assign trial    = {drem_ff, num_ff[WB-1]};
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, a_ff};
   // k*inv = j*r + 1 and k*(r - inv) = (k - j)*r - 1
   assign num_a    = jr_ff + WB'(1);
   assign num_b    = kr_ff - jr_ff - WB'(1);
   assign use_a    = num_a < num_b;
   assign t_val    = num_ff[MB-2:0];
   assign r_two    = r_ff == MB'(2);

   always_comb begin
      status.skip     = (r_ff <= MB'(1)) || (max_mult < KB'(2));
      status.div_done = cnt_ff == '0;
      status.hit      = acc_ff == (k_ff - KB'(1));
      status.miss     = j_ff == (k_ff - KB'(1));
      status.last_k   = k_ff >= max_mult;
      status.rsp_full = vld_ff && rsp_stall;
   end

   always_comb begin
      r_in = r_ff; k_in = k_ff; kr_in = kr_ff;
      num_in = num_ff; drem_in = drem_ff; cnt_in = cnt_ff;
      a_in = a_ff; j_in = j_ff; acc_in = acc_ff; jr_in = jr_ff;
      ckt_in = ckt_ff; cplus_in = cplus_ff; cq_in = cq_ff;
      found_in = found_ff; bk_in = bk_ff; bt_in = bt_ff;
      bkt_in = bkt_ff; bplus_in = bplus_ff; bq_in = bq_ff;
      if (cmd.load) begin
         r_in     = req_wide[MB-1:0];
         k_in     = KB'(2);
         kr_in    = WB'(req_wide[MB-1:0]) << 1;
         found_in = 1'b0;
         bk_in    = '0;
         bt_in    = '0;
         bkt_in   = '0;
         bplus_in = 1'b0;
         bq_in    = '0;
      end
      if (cmd.mod_start) begin
         num_in  = WB'(r_ff);
         drem_in = '0;
         cnt_in  = CB'(WB);
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, k_ff}) begin
            drem_in = KB'(trial - {1'b0, k_ff});
            num_in  = {num_ff[WB-2:0], 1'b1};
         end else begin
            drem_in = trial[KB-1:0];
            num_in  = {num_ff[WB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
      end
      if (cmd.search_init) begin
         a_in   = drem_ff;
         j_in   = '0;
         acc_in = '0;
         jr_in  = '0;
      end
      if (cmd.search_step) begin
         j_in   = j_ff + KB'(1);
         jr_in  = jr_ff + WB'(r_ff);
         acc_in = (acc_sum >= {1'b0, k_ff}) ? KB'(acc_sum - {1'b0, k_ff}) : acc_sum[KB-1:0];
      end
      if (cmd.t_start) begin
         num_in  = use_a ? num_a : num_b;
         drem_in = '0;
         cnt_in  = CB'(WB);
         ckt_in  = use_a ? num_a : num_b;
         // the r-1 residue is tested first, so modulus two always reads as minus
         if (use_a && !r_two) begin
            cplus_in = 1'b1;
            cq_in    = j_ff;
         end else if (use_a) begin
            cplus_in = 1'b0;
            cq_in    = j_ff + KB'(1);
         end else begin
            cplus_in = 1'b0;
            cq_in    = k_ff - j_ff;
         end
      end
      if (cmd.update && (!found_ff || t_val < bt_ff)) begin
         found_in = 1'b1;
         bk_in    = k_ff;
         bt_in    = t_val;
         bkt_in   = ckt_ff;
         bplus_in = cplus_ff;
         bq_in    = cq_ff;
      end
      if (cmd.next_k) begin
         k_in  = k_ff + KB'(1);
         kr_in = kr_ff + WB'(r_ff);
      end
   end

   always_comb begin
      vld_in     = vld_ff && rsp_stall;
      o_found_in = o_found_ff;
      o_k_in     = o_k_ff;
      o_t_in     = o_t_ff;
      o_kt_in    = o_kt_ff;
      o_plus_in  = o_plus_ff;
      o_q_in     = o_q_ff;
      if (cmd.publish) begin
         vld_in     = 1'b1;
         o_found_in = found_ff;
         o_k_in     = bk_ff;
         o_t_in     = bt_ff;
         o_kt_in    = bkt_ff;
         o_plus_in  = bplus_ff;
         o_q_in     = bq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; k_ff <= k_in; kr_ff <= kr_in;
      num_ff <= num_in; drem_ff <= drem_in;
      a_ff <= a_in; j_ff <= j_in; acc_ff <= acc_in; jr_ff <= jr_in;
      ckt_ff <= ckt_in; cplus_ff <= cplus_in; cq_ff <= cq_in;
      found_ff <= found_in; bk_ff <= bk_in; bt_ff <= bt_in;
      bkt_ff <= bkt_in; bplus_ff <= bplus_in; bq_ff <= bq_in;
      o_found_ff <= o_found_in; o_k_ff <= o_k_in; o_t_ff <= o_t_in;
      o_kt_ff <= o_kt_in; o_plus_ff <= o_plus_in; o_q_ff <= o_q_in;
   end

   assign t_wide              = 64'(o_t_ff);
   assign kt_wide             = 64'(o_kt_ff);
   assign rsp_valid           = vld_ff;
   assign rsp_found           = o_found_ff;
   assign rsp_best_multiplier = 8'(o_k_ff);
   assign rsp_best_offset     = t_wide[30:0];
   assign rsp_product         = kt_wide[39:0];
   assign rsp_sign_plus       = o_plus_ff;
   assign rsp_quotient        = 8'(o_q_ff);

endmodule

// ===== rtl/core/mmiw_controller.sv =====
// controller state machine sequencing the per-multiplier search
// depends on mmiw_pkg for state, command and status types
module mmiw_controller
   import mmiw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = status.skip ? ST_DONE : ST_MOD;
         ST_MOD:    if (status.div_done) state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (status.hit) state_in = ST_DIV;
            else if (status.miss) state_in = ST_NEXT;
         end
         ST_DIV:    if (status.div_done) state_in = ST_NEXT;
         ST_NEXT:   state_in = status.last_k ? ST_DONE : ST_CHECK;
         ST_DONE:   if (!status.rsp_full) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK:  cmd.mod_start = !status.skip;
         ST_MOD: begin
            cmd.search_init = status.div_done;
            cmd.div_step    = !status.div_done;
         end
         ST_SEARCH: begin
            cmd.t_start     = status.hit;
            cmd.search_step = !status.hit && !status.miss;
         end
         ST_DIV: begin
            cmd.update   = status.div_done;
            cmd.div_step = !status.div_done;
         end
         ST_NEXT:   cmd.next_k  = !status.last_k;
         ST_DONE:   cmd.publish = !status.rsp_full;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/min_modular_inverse_witness.sv =====
// each k runs the shared bit-serial divider for r mod k, then an accumulate search over j up to
// k - 1 for the inverse; only when one is found does the divider run again for t = k*t / k
// one request is worked at a time; the next is taken while a result waits in the output register
// reset is synchronous and active high: max_multiplier returns to 20, no result pending
// top level: controller + datapath, csr register; depends on mmiw_pkg
module min_modular_inverse_witness
   import mmiw_pkg::*;
#(
   parameter int MOD_BITS  = 32,
   parameter int MULT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [7:0]  rsp_best_multiplier,
   output logic [30:0] rsp_best_offset,
   output logic [39:0] rsp_product,
   output logic        rsp_sign_plus,
   output logic [7:0]  rsp_quotient
);

   localparam int ResetMax = 20;

   logic [MULT_BITS-1:0] max_ff, max_in;
   cmd_type              cmd;
   status_type           status;

   assign max_in = csr_wr_en ? csr_wr_data[MULT_BITS-1:0] : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MULT_BITS'(ResetMax);
      end else begin
         max_ff <= max_in;
      end
   end

   mmiw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mmiw_datapath #(
      .MOD_BITS  (MOD_BITS),
      .MULT_BITS (MULT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_modulus         (req_modulus),
      .max_mult            (max_ff),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_found           (rsp_found),
      .rsp_best_multiplier (rsp_best_multiplier),
      .rsp_best_offset     (rsp_best_offset),
      .rsp_product         (rsp_product),
      .rsp_sign_plus       (rsp_sign_plus),
      .rsp_quotient        (rsp_quotient)
   );

`ifndef SYNTHESIS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("controller not busy after request");
   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_best_multiplier >= 8'd2 && rsp_best_offset != 31'd0)
      else $error("witness with bad multiplier or offset");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_product == 40'd0 && rsp_quotient == 8'd0)
      else $error("empty result carries data");
`endif

endmodule
